// ===== hdl/sbda_pkg.sv =====
// shared constants for the signed binary to decimal ascii converter
// no dependencies
package sbda_pkg;

  localparam int CHAR_W = 6;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] ASCII_MINUS = CHAR_W'(45);

  localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [3:0] BCD_ADJ_ADD = 4'd3;

endpackage

// ===== hdl/sbda_front.sv =====
// front stage: accepts a value, splits it into sign and unsigned magnitude
// and holds it until the queue takes it; uses sbda_pkg
module sbda_front import sbda_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DATA_WIDTH-1:0] in_value,
  output logic                  push,
  input  logic                  q_full,
  output logic [DATA_WIDTH:0]   push_data
);

  logic                  f_valid_r, f_valid_nxt;
  logic                  f_neg_r;
  logic [DATA_WIDTH-1:0] f_mag_r;
  logic                  accept;
  logic                  neg;
  logic [DATA_WIDTH-1:0] mag;

  assign in_stall  = f_valid_r && q_full;
  assign accept    = in_valid && !in_stall;
  assign push      = f_valid_r && !q_full;
  assign push_data = {f_neg_r, f_mag_r};

  // most negative value negates to itself, which is the right unsigned magnitude
  assign neg = in_value[DATA_WIDTH-1];
  assign mag = neg ? (~in_value + DATA_WIDTH'(1)) : in_value;

  always_comb begin
    f_valid_nxt = f_valid_r;
    if (accept) begin
      f_valid_nxt = 1'b1;
    end else if (push) begin
      f_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_neg_r <= neg;
      f_mag_r <= mag;
    end
  end

endmodule

// ===== hdl/sbda_queue.sv =====
// two-entry queue between front and back, head always in slot zero
// uses sbda_pkg
module sbda_queue import sbda_pkg::*; #(
  parameter int WIDTH = 33
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] head
);

  logic [1:0]       cnt_r, cnt_nxt;
  logic [WIDTH-1:0] e0_r, e0_nxt;
  logic [WIDTH-1:0] e1_r, e1_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = e0_r;

  always_comb begin
    cnt_nxt = cnt_r;
    e0_nxt  = e0_r;
    e1_nxt  = e1_r;
    if (push && pop) begin
      if (cnt_r == 2'd1) begin
        e0_nxt = push_data;
      end else begin
        e0_nxt = e1_r;
        e1_nxt = push_data;
      end
    end else if (pop) begin
      e0_nxt  = e1_r;
      cnt_nxt = cnt_r - 2'd1;
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        e0_nxt = push_data;
      end else begin
        e1_nxt = push_data;
      end
      cnt_nxt = cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e0_r <= e0_nxt;
    e1_r <= e1_nxt;
  end

endmodule

// ===== hdl/sbda_back.sv =====
// back end: bit-serial double dabble to bcd, then emits sign and digits
// through an output register; uses sbda_pkg
module sbda_back import sbda_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  logic [DATA_WIDTH:0]   q_head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CHAR_W-1:0]     out_character,
  output logic                  out_last
);

  localparam int NDIG = (DATA_WIDTH * 301) / 1000 + 1;
  localparam int PW   = $clog2(NDIG);
  localparam int CW   = $clog2(DATA_WIDTH);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_FIND = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [PW-1:0]         ptr_r, ptr_nxt;
  logic                  sign_r, sign_nxt;
  logic [DATA_WIDTH-1:0] sh_r, sh_nxt;
  logic [3:0]            dig_r   [NDIG];
  logic [3:0]            dig_nxt [NDIG];
  logic [3:0]            adj     [NDIG];
  logic [PW-1:0]         lead;
  logic                  emit;
  logic                  out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]     out_char_r;
  logic                  out_last_r;
  logic [CHAR_W-1:0]     char_nxt;
  logic                  last_nxt;

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

  assign pop  = (state_r == ST_IDLE) && !q_empty;
  assign emit = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);

  // add-3 correction per digit before each shift
  always_comb begin
    for (int k = 0; k < NDIG; k++) begin
      adj[k] = (dig_r[k] >= BCD_ADJ_MIN) ? (dig_r[k] + BCD_ADJ_ADD) : dig_r[k];
    end
  end

  // highest nonzero digit, zero if all digits are zero
  always_comb begin
    lead = '0;
    for (int k = 0; k < NDIG; k++) begin
      if (dig_r[k] != 4'd0) begin
        lead = PW'(k);
      end
    end
  end

  always_comb begin
    if (sign_r) begin
      char_nxt = ASCII_MINUS;
      last_nxt = 1'b0;
    end else begin
      char_nxt = ASCII_ZERO + {{(CHAR_W-4){1'b0}}, dig_r[ptr_r]};
      last_nxt = (ptr_r == '0);
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ptr_nxt   = ptr_r;
    sign_nxt  = sign_r;
    sh_nxt    = sh_r;
    for (int k = 0; k < NDIG; k++) begin
      dig_nxt[k] = dig_r[k];
    end
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          sign_nxt  = q_head[DATA_WIDTH];
          sh_nxt    = q_head[DATA_WIDTH-1:0];
          cnt_nxt   = CW'(DATA_WIDTH - 1);
          for (int k = 0; k < NDIG; k++) begin
            dig_nxt[k] = 4'd0;
          end
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        dig_nxt[0] = {adj[0][2:0], sh_r[DATA_WIDTH-1]};
        for (int k = 1; k < NDIG; k++) begin
          dig_nxt[k] = {adj[k][2:0], adj[k-1][3]};
        end
        sh_nxt = sh_r << 1;
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_FIND;
        end
      end
      ST_FIND: begin
        ptr_nxt   = lead;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit) begin
          if (sign_r) begin
            sign_nxt = 1'b0;
          end else if (ptr_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            ptr_nxt = ptr_r - PW'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    ptr_r  <= ptr_nxt;
    sign_r <= sign_nxt;
    sh_r   <= sh_nxt;
    for (int k = 0; k < NDIG; k++) begin
      dig_r[k] <= dig_nxt[k];
    end
    if (emit) begin
      out_char_r <= char_nxt;
      out_last_r <= last_nxt;
    end
  end

endmodule

// ===== hdl/signed_binary_to_decimal_ascii.sv =====
// top level of the signed binary to decimal ascii converter
// instantiates sbda_front, sbda_queue and sbda_back; uses sbda_pkg
//
//   channel  ports                                   transaction
//   in       in_valid, in_stall, in_value            one signed integer
//   out      out_valid, out_stall, out_character,    one ascii character,
//            out_last                                out_last on the final one
//
// a value leaves the queue, goes through bit-serial double dabble, has its
// leading digit found and then goes out one character per cycle (sign plus
// digits) unless out_stall holds the output back
// the two-entry queue lets the front take new values while the back converts
// reset clears the valid flags, the queue count and the state machine
module signed_binary_to_decimal_ascii import sbda_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DATA_WIDTH-1:0] in_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CHAR_W-1:0]     out_character,
  output logic                  out_last
);

  logic                push;
  logic                q_full;
  logic [DATA_WIDTH:0] push_data;
  logic                pop;
  logic                q_empty;
  logic [DATA_WIDTH:0] q_head;

  sbda_front #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_value  (in_value),
    .push      (push),
    .q_full    (q_full),
    .push_data (push_data)
  );

  sbda_queue #(
    .WIDTH(DATA_WIDTH + 1)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  sbda_back #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule
